// File: rtl/core/hsc_pkg.sv
package hsc_pkg;

    localparam int STORE_BYTES_DEF = 131072;
    localparam logic [31:0] BASE_RESET = 32'h2000_0000;

    localparam int SEQ_W  = 32;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 18;
    localparam int OFS_W  = 17;

    localparam logic [SIZE_W-1:0] CNT_MAX = '1;

    // apb register map, word index taken from paddr[2]
    localparam int   PADDR_W         = 3;
    localparam logic REG_REGION_BASE = 1'b0;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_REALLOC = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SEQ_W-1:0]  seq_number;
        logic [ADDR_W-1:0] first_address;
        logic [SIZE_W-1:0] first_size;
        logic [ADDR_W-1:0] second_address;
        logic [SIZE_W-1:0] second_size;
    } t_event;

    typedef struct packed {
        logic [SEQ_W-1:0]  owner;
        logic [SIZE_W-1:0] size;
        logic [OFS_W-1:0]  offset;
    } t_shadow;

    typedef struct packed {
        logic [SIZE_W-1:0] alloc_conflicts;
        logic [SEQ_W-1:0]  first_owner;
        logic [SIZE_W-1:0] free_errors;
        logic [OFS_W-1:0]  first_bad_offset;
        logic              range_error;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_SIZE_WAIT,
        ST_RANGE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/hsc_shadow_ram.sv
module hsc_shadow_ram #(
    parameter int  DEPTH = hsc_pkg::STORE_BYTES_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  hsc_pkg::t_shadow i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output hsc_pkg::t_shadow o_rd_data
);
    import hsc_pkg::*;

    t_shadow r_mem [DEPTH];
    t_shadow r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/hsc_byte_unit.sv
module hsc_byte_unit (
    input  logic                        i_op_free,
    input  logic [hsc_pkg::SEQ_W-1:0]   i_seq,
    input  logic [hsc_pkg::SIZE_W-1:0]  i_len,
    input  logic [hsc_pkg::SIZE_W-1:0]  i_pidx,
    input  hsc_pkg::t_shadow            i_rd,
    output hsc_pkg::t_shadow            o_wr,
    output logic                        o_hit
);
    import hsc_pkg::*;

    logic [OFS_W-1:0] w_ofs;

    assign w_ofs = i_pidx[OFS_W-1:0];

    always_comb begin
        if (i_op_free) begin
            // unowned byte or offset that does not match its place in the block
            o_hit       = (i_rd.owner == '0) || (i_rd.offset != w_ofs);
            o_wr.owner  = '0;
            o_wr.size   = i_rd.size;
            o_wr.offset = '0;
        end else begin
            o_hit       = (i_rd.owner != '0);
            o_wr.owner  = i_seq;
            o_wr.size   = i_len;
            o_wr.offset = w_ofs;
        end
    end

endmodule

// File: rtl/core/hsc_ctrl.sv
module hsc_ctrl #(
    parameter int  STORE_BYTES = hsc_pkg::STORE_BYTES_DEF,
    localparam int AW          = $clog2(STORE_BYTES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hsc_pkg::ADDR_W-1:0]  i_base,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  hsc_pkg::t_event             i_in,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output hsc_pkg::t_result            o_res,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    input  hsc_pkg::t_shadow            i_rd_data,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output hsc_pkg::t_shadow            o_wr_data
);
    import hsc_pkg::*;

    localparam logic [AW-1:0]     CLR_LAST  = AW'(STORE_BYTES - 1);
    localparam logic [ADDR_W:0]   STORE_LIM = (ADDR_W + 1)'(STORE_BYTES);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [ADDR_W-1:0]   r_addr2, n_addr2;
    logic [SIZE_W-1:0]   r_size2, n_size2;
    logic                r_op_free, n_op_free;
    logic                r_then_alloc, n_then_alloc;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [SIZE_W-1:0]   r_len, n_len;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [SIZE_W-1:0]   r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [SIZE_W-1:0]   r_pidx, n_pidx;
    t_result             r_res, n_res;

    logic                w_free_skip;
    logic                w_need_size;
    logic                w_pos_out;
    logic                w_range_bad;
    logic                w_issue;
    logic                w_phase_end;
    logic                w_chain;
    logic [AW-1:0]       w_pos_ix;
    t_shadow             w_unit_wr;
    logic                w_unit_hit;

    hsc_byte_unit u_byte_unit (
        .i_op_free (r_op_free),
        .i_seq     (r_seq),
        .i_len     (r_len),
        .i_pidx    (r_pidx),
        .i_rd      (i_rd_data),
        .o_wr      (w_unit_wr),
        .o_hit     (w_unit_hit)
    );

    assign w_free_skip = r_op_free && (r_addr == '0);
    assign w_need_size = r_op_free && (r_len == '0);
    assign w_pos_out   = {1'b0, r_pos} >= STORE_LIM;
    assign w_range_bad = ({1'b0, r_pos} + (ADDR_W + 1)'(r_len)) > STORE_LIM;
    assign w_issue     = (r_idx != r_len);
    assign w_chain     = r_op_free && r_then_alloc;
    assign w_pos_ix    = r_pos[AW-1:0];

    // end of the free or allocate part of the current event
    always_comb begin
        case (r_state)
            ST_CHECK: w_phase_end = w_free_skip || (w_need_size && w_pos_out);
            ST_RANGE: w_phase_end = w_range_bad || (r_len == '0);
            ST_RUN:   w_phase_end = !w_issue && !r_pend;
            default:  w_phase_end = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in.kind == KIND_NONE) ? ST_DONE : ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_CHECK;
            ST_CHECK: begin
                if (!w_phase_end) begin
                    n_state = w_need_size ? ST_SIZE_WAIT : ST_RANGE;
                end
            end
            ST_SIZE_WAIT: n_state = ST_RANGE;
            ST_RANGE: begin
                if (!w_phase_end) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: n_state = r_state;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (w_phase_end) begin
            n_state = w_chain ? ST_SETUP : ST_DONE;
        end
    end

    always_comb begin
        n_clr        = r_clr;
        n_seq        = r_seq;
        n_addr2      = r_addr2;
        n_size2      = r_size2;
        n_op_free    = r_op_free;
        n_then_alloc = r_then_alloc;
        n_addr       = r_addr;
        n_len        = r_len;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_res        = r_res;
        o_rd_en      = 1'b0;
        o_rd_addr    = w_pos_ix + AW'(r_idx);
        o_wr_en      = 1'b0;
        o_wr_addr    = w_pos_ix + AW'(r_pidx);
        o_wr_data    = w_unit_wr;
        case (r_state)
            ST_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = '0;
                n_clr     = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_seq        = i_in.seq_number;
                    n_addr2      = i_in.second_address;
                    n_size2      = i_in.second_size;
                    n_op_free    = (i_in.kind != KIND_ALLOC);
                    n_then_alloc = (i_in.kind == KIND_REALLOC);
                    n_addr       = i_in.first_address;
                    n_len        = i_in.first_size;
                    n_res        = '0;
                end
            end
            ST_SETUP: n_pos = r_addr - i_base;
            ST_CHECK: begin
                if (!w_free_skip && w_need_size) begin
                    if (w_pos_out) begin
                        n_res.range_error = 1'b1;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_pos_ix;
                    end
                end
            end
            ST_SIZE_WAIT: n_len = i_rd_data.size;
            ST_RANGE: begin
                if (w_range_bad) begin
                    n_res.range_error = 1'b1;
                end
                n_idx  = '0;
                n_pend = 1'b0;
            end
            ST_RUN: begin
                // read of the next byte overlaps the write-back of the previous one
                n_pend = w_issue;
                if (w_issue) begin
                    o_rd_en = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_pidx  = r_idx;
                end
                if (r_pend) begin
                    o_wr_en = 1'b1;
                    if (w_unit_hit) begin
                        if (r_op_free) begin
                            if (r_res.free_errors == '0) begin
                                n_res.first_bad_offset = i_rd_data.offset;
                            end
                            if (r_res.free_errors != CNT_MAX) begin
                                n_res.free_errors = r_res.free_errors + 1'b1;
                            end
                        end else begin
                            if (r_res.alloc_conflicts == '0) begin
                                n_res.first_owner = i_rd_data.owner;
                            end
                            if (r_res.alloc_conflicts != CNT_MAX) begin
                                n_res.alloc_conflicts = r_res.alloc_conflicts + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DONE: n_res = r_res;
            default: n_res = r_res;
        endcase
        if (w_phase_end && w_chain) begin
            n_op_free    = 1'b0;
            n_then_alloc = 1'b0;
            n_addr       = r_addr2;
            n_len        = r_size2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq        <= n_seq;
        r_addr2      <= n_addr2;
        r_size2      <= n_size2;
        r_op_free    <= n_op_free;
        r_then_alloc <= n_then_alloc;
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_res        <= n_res;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

// File: rtl/core/heap_shadow_checker_core.sv
// heap shadow checker: one heap trace event in, one summary result out.
// s_axis carries the event (tuser holds the kind), m_axis carries the
// summary; both are accepted when tvalid and tready are high at a clock edge.
// the apb port holds region_base, the address of the first tracked byte;
// write it only while no event is in flight.
// every tracked byte has one shadow entry (owner, block size, offset) in a
// single-port-write, single-port-read ram, walked one byte per cycle.
// each free or allocate part passes the setup, check and range states, then walks its
// block; reallocate runs a free part then an allocate part, an unused kind goes
// straight to the result, and a free of size 0 first fetches the stored size.
// one event at a time: s_axis_tready is high only while the sequencer idles.
// after reset the ram is swept to zero, one entry per cycle over all STORE_BYTES
// entries, with s_axis_tready low; apb writes are taken during the sweep.
// a finished summary sits in the output register; when the receiver stalls
// the next event is still taken and runs, and its summary waits for the slot.
module heap_shadow_checker_core #(
    parameter int STORE_BYTES = hsc_pkg::STORE_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // seq_number, first_address, first_size, second_address, second_size, pad
    input  logic [135:0]                 s_axis_tdata,
    // kind
    input  logic [1:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // alloc_conflicts, first_owner, free_errors, first_bad_offset, range_error, pad
    output logic [87:0]                  m_axis_tdata
);
    import hsc_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [ADDR_W-1:0] r_base;
    logic              r_out_valid;
    t_result           r_out;

    t_event            w_event;
    logic              w_res_valid;
    logic              w_res_ready;
    t_result           w_res;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    t_shadow           w_rd_data;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_shadow           w_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_REGION_BASE)) begin
            r_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REGION_BASE) ? r_base : '0;

    assign w_event.kind           = t_kind'(s_axis_tuser);
    assign w_event.seq_number     = s_axis_tdata[31:0];
    assign w_event.first_address  = s_axis_tdata[63:32];
    assign w_event.first_size     = s_axis_tdata[81:64];
    assign w_event.second_address = s_axis_tdata[113:82];
    assign w_event.second_size    = s_axis_tdata[131:114];

    hsc_ctrl #(
        .STORE_BYTES (STORE_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_base),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in        (w_event),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    hsc_shadow_ram #(
        .DEPTH (STORE_BYTES)
    ) u_shadow_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output slot frees up in the same cycle it is taken
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.range_error, r_out.first_bad_offset,
                            r_out.free_errors, r_out.first_owner, r_out.alloc_conflicts};

endmodule
